FILE: sv/interrupt_vector_slot_manager_top_assert.svh
// ----------------------------------------------------------------------------
// interrupt vector slot manager assertion macros
// shared property forms for the slot table control logic
// ----------------------------------------------------------------------------
`ifndef INTERRUPT_VECTOR_SLOT_MANAGER_TOP_ASSERT_SVH
`define INTERRUPT_VECTOR_SLOT_MANAGER_TOP_ASSERT_SVH

// same-cycle implication
`define IVSM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ivsm assertion failed");

// next-cycle implication
`define IVSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ivsm assertion failed");

`endif

FILE: sv/ivsm_pkg.sv
// ----------------------------------------------------------------------------
// ivsm_pkg
// opcodes, status codes and slot attribute type of the vector slot table
// ----------------------------------------------------------------------------
package ivsm_pkg;

   localparam logic [2:0] OP_REGISTER       = 3'd0;
   localparam logic [2:0] OP_UNREGISTER     = 3'd1;
   localparam logic [2:0] OP_ENABLE         = 3'd2;
   localparam logic [2:0] OP_DISABLE        = 3'd3;
   localparam logic [2:0] OP_UNREGISTER_ALL = 3'd4;
   localparam logic [2:0] OP_DISABLE_ALL    = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SOURCE = 3'd1;
   localparam logic [2:0] ST_NULL_ADDR  = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

   typedef struct packed {
      logic        valid;
      logic        enable;
      logic [31:0] handler;
   } slot_attr_type;

endpackage

FILE: sv/ivsm_cell.sv
// ----------------------------------------------------------------------------
// ivsm_cell
// one slot of the table, shifts to its neighbour and compares its source
// ----------------------------------------------------------------------------
module ivsm_cell #(
   parameter int SRC_W = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  ivsm_pkg::slot_attr_type next_attr,
   input  logic [SRC_W-1:0]       next_src,
   input  logic [SRC_W-1:0]       key,
   output ivsm_pkg::slot_attr_type attr,
   output logic [SRC_W-1:0]       src,
   output logic                   match
);
   import ivsm_pkg::*;

   slot_attr_type    attr_ff;
   logic [SRC_W-1:0] src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= '0;
         src_ff  <= '0;
      end else if (shift_en) begin
         attr_ff <= next_attr;
         src_ff  <= next_src;
      end
   end

   assign attr  = attr_ff;
   assign src   = src_ff;
   assign match = attr_ff.valid && (src_ff == key);

endmodule

FILE: sv/ivsm_ctrl.sv
// ----------------------------------------------------------------------------
// ivsm_ctrl
// sequencer at the head of the slot ring: edits each slot as it passes,
// collects the reported slot and holds the result word
// ----------------------------------------------------------------------------
`include "interrupt_vector_slot_manager_top_assert.svh"

module ivsm_ctrl #(
   parameter int SLOT_COUNT   = 16,
   parameter int SOURCE_COUNT = 32,
   parameter int SRC_W        = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_opcode,
   input  logic [7:0]              req_source,
   input  logic [31:0]             req_handler_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [3:0]              rsp_slot,
   output logic                    rsp_slot_enabled,
   output logic [31:0]             rsp_slot_address,
   input  logic [31:0]             default_addr,
   input  logic [SLOT_COUNT-1:0]   match,
   input  ivsm_pkg::slot_attr_type head_attr,
   input  logic [SRC_W-1:0]        head_src,
   output ivsm_pkg::slot_attr_type tail_attr,
   output logic [SRC_W-1:0]        tail_src,
   output logic [SRC_W-1:0]        key,
   output logic                    shift_en
);
   import ivsm_pkg::*;

   localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_PREP   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [2:0]        op_ff;
   logic [7:0]        src_ff;
   logic [31:0]       addr_ff;
   logic [SLOT_W-1:0] count_ff, count_in;
   logic              hit_any_ff, hit_any_in;
   logic              done_ff, done_in;
   logic [SLOT_W-1:0] rep_slot_ff, rep_slot_in;
   logic              rep_en_ff, rep_en_in;
   logic [31:0]       rep_addr_ff, rep_addr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [3:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_en_ff, rsp_en_in;
   logic [31:0]       rsp_addr_ff, rsp_addr_in;

   logic              bad_src, null_addr, act, all_op, head_hit, take, last, load;
   logic [2:0]        status;

   assign key       = src_ff[SRC_W-1:0];
   assign req_ready = (state_ff == S_IDLE);
   assign shift_en  = (state_ff == S_SCAN);
   assign last      = (count_ff == SLOT_W'(SLOT_COUNT - 1));
   assign load      = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign bad_src   = (op_ff <= OP_DISABLE) && (src_ff >= 8'(SOURCE_COUNT));
   assign null_addr = (op_ff == OP_REGISTER) && (addr_ff == '0);
   assign act       = !bad_src && !null_addr;
   assign all_op    = (op_ff == OP_UNREGISTER_ALL) || (op_ff == OP_DISABLE_ALL);
   assign head_hit  = head_attr.valid && (head_src == key);

   // edit of the slot leaving the head
   always_comb begin
      tail_attr = head_attr;
      tail_src  = head_src;
      take      = 1'b0;
      unique case (op_ff)
         OP_REGISTER: begin
            if (act && !done_ff && (hit_any_ff ? head_hit : !head_attr.valid)) begin
               tail_attr = '{valid: 1'b1, enable: 1'b1, handler: addr_ff};
               tail_src  = key;
               take      = 1'b1;
            end
         end
         OP_UNREGISTER: begin
            if (act && head_hit) begin
               tail_attr = '{valid: 1'b0, enable: 1'b0, handler: default_addr};
               tail_src  = '0;
               take      = 1'b1;
            end
         end
         OP_ENABLE: begin
            if (act && head_hit && !done_ff) begin
               tail_attr.enable = 1'b1;
               take             = 1'b1;
            end
         end
         OP_DISABLE: begin
            if (act && head_hit) begin
               tail_attr.enable = 1'b0;
               take             = 1'b1;
            end
         end
         OP_UNREGISTER_ALL: begin
            tail_attr = '{valid: 1'b0, enable: 1'b0, handler: default_addr};
            tail_src  = '0;
         end
         OP_DISABLE_ALL: begin
            tail_attr.enable = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      priority if (bad_src) begin
         status = ST_BAD_SOURCE;
      end else if (null_addr) begin
         status = ST_NULL_ADDR;
      end else if (op_ff == OP_REGISTER && !done_ff) begin
         status = ST_FULL;
      end else if (op_ff <= OP_DISABLE && !done_ff) begin
         status = ST_NOT_FOUND;
      end else begin
         status = ST_OK;
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      hit_any_in  = hit_any_ff;
      done_in     = done_ff;
      rep_slot_in = rep_slot_ff;
      rep_en_in   = rep_en_ff;
      rep_addr_in = rep_addr_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            hit_any_in  = |match;
            done_in     = 1'b0;
            count_in    = '0;
            rep_slot_in = '0;
            rep_en_in   = 1'b0;
            rep_addr_in = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            if ((take && !done_ff) || (all_op && count_ff == '0)) begin
               rep_slot_in = count_ff;
               rep_en_in   = tail_attr.enable;
               rep_addr_in = tail_attr.handler;
            end
            if (take) begin
               done_in = 1'b1;
            end
            count_in = count_ff + SLOT_W'(1);
            if (last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_en_in     = rsp_en_ff;
      rsp_addr_in   = rsp_addr_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_slot_in   = 4'(rep_slot_ff);
         rsp_en_in     = rep_en_ff;
         rsp_addr_in   = rep_addr_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         hit_any_ff   <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
         hit_any_ff   <= hit_any_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_opcode;
         src_ff  <= req_source;
         addr_ff <= req_handler_address;
      end
      rep_slot_ff   <= rep_slot_in;
      rep_en_ff     <= rep_en_in;
      rep_addr_ff   <= rep_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_en_ff     <= rsp_en_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_slot_enabled = rsp_en_ff;
   assign rsp_slot_address = rsp_addr_ff;

   `IVSM_ASSERT_NEXT(a_accept_prep, clock, reset, req_valid && req_ready, state_ff == S_PREP)
   `IVSM_ASSERT_NEXT(a_scan_end, clock, reset, state_ff == S_SCAN && last, state_ff == S_FINISH)
   `IVSM_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid_ff && rsp_status_ff != ST_OK,
                    rsp_slot_ff == '0 && !rsp_en_ff && rsp_addr_ff == '0)
   `IVSM_ASSERT_NOW(a_enable_once, clock, reset,
                    state_ff == S_SCAN && op_ff == OP_ENABLE && done_ff,
                    tail_attr == head_attr)

endmodule

FILE: sv/interrupt_vector_slot_manager_top.sv
// ----------------------------------------------------------------------------
// interrupt_vector_slot_manager_top
// vector slot table kept in a ring of slot cells, edited at the ring head
//
//  channel  dir  handshake            word
//  req      in   req_valid/req_ready  opcode, source, handler address
//  rsp      out  rsp_valid/rsp_ready  status, slot, enable bit, address
//  csr      in   csr_wr_en            default handler address
//
// an item goes through these steps: the request word is latched, the source is
// matched over all cells, each slot passes the head once, the result is loaded
// synchronous reset clears every slot and the default address at once
// a held result stalls the sequencer in its last state; no new word is taken
// until the result register has been loaded
// ----------------------------------------------------------------------------
module interrupt_vector_slot_manager_top #(
   parameter int SLOT_COUNT   = 16,
   parameter int SOURCE_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_source,
   input  logic [31:0] req_handler_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic        rsp_slot_enabled,
   output logic [31:0] rsp_slot_address,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import ivsm_pkg::*;

   localparam int SRC_W = $clog2(SOURCE_COUNT);

   logic [31:0]         default_isr_address_ff;
   slot_attr_type       cell_attr [SLOT_COUNT];
   logic [SRC_W-1:0]    cell_src  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] match;
   slot_attr_type       tail_attr;
   logic [SRC_W-1:0]    tail_src;
   logic [SRC_W-1:0]    key;
   logic                shift_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_isr_address_ff <= '0;
      end else if (csr_wr_en) begin
         default_isr_address_ff <= csr_wr_data;
      end
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      slot_attr_type    next_attr;
      logic [SRC_W-1:0] next_src;
      if (i == SLOT_COUNT - 1) begin : g_tail
         assign next_attr = tail_attr;
         assign next_src  = tail_src;
      end else begin : g_mid
         assign next_attr = cell_attr[i+1];
         assign next_src  = cell_src[i+1];
      end
      ivsm_cell #(
         .SRC_W(SRC_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .next_attr(next_attr),
         .next_src (next_src),
         .key      (key),
         .attr     (cell_attr[i]),
         .src      (cell_src[i]),
         .match    (match[i])
      );
   end

   ivsm_ctrl #(
      .SLOT_COUNT  (SLOT_COUNT),
      .SOURCE_COUNT(SOURCE_COUNT),
      .SRC_W       (SRC_W)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_source         (req_source),
      .req_handler_address(req_handler_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot           (rsp_slot),
      .rsp_slot_enabled   (rsp_slot_enabled),
      .rsp_slot_address   (rsp_slot_address),
      .default_addr       (default_isr_address_ff),
      .match              (match),
      .head_attr          (cell_attr[0]),
      .head_src           (cell_src[0]),
      .tail_attr          (tail_attr),
      .tail_src           (tail_src),
      .key                (key),
      .shift_en           (shift_en)
   );

endmodule
